/* sv/ssms_pkg.sv */
// ssms_pkg: types, constants and enums shared by the stock span stack block.
// No dependencies; every other file in sv/ imports this package.
package ssms_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int SPAN_WIDTH  = 16;
  localparam int PRICE_WIDTH = 32;
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);

  typedef logic [PRICE_WIDTH-1:0] key_t;
  typedef logic [SPAN_WIDTH-1:0]  span_t;
  typedef logic [FILL_W-1:0]      fill_t;

  localparam span_t SPAN_MAX   = {SPAN_WIDTH{1'b1}};
  localparam fill_t FILL_FULL  = FILL_W'(STACK_DEPTH);
  localparam fill_t FILL_EMPTY = '0;

  typedef struct packed {
    logic signed [PRICE_WIDTH-1:0] price;
    logic                          series_start;
  } in_item_t;

  typedef struct packed {
    span_t span;
    logic  inexact;
  } out_item_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_WORK
  } state_e;

  // Command from the controller to the cell chain; key/span enter at the top cell.
  typedef struct packed {
    cell_op_e op;
    key_t     key;
    span_t    span;
  } cell_ctrl_t;

  // Flip the sign bit so an unsigned compare orders signed prices.
  function automatic key_t price_to_key(input logic signed [PRICE_WIDTH-1:0] price);
    key_t k;
    k = key_t'(price);
    k[PRICE_WIDTH-1] = ~k[PRICE_WIDTH-1];
    return k;
  endfunction

endpackage

/* sv/ssms_cell.sv */
// ssms_cell: one stack entry (key, span); shifts down on push, up on pop.
// Depends on ssms_pkg.
module ssms_cell import ssms_pkg::*; (
  input  logic     clk,
  input  cell_op_e op,
  input  key_t     up_key,
  input  span_t    up_span,
  input  key_t     dn_key,
  input  span_t    dn_span,
  output key_t     key,
  output span_t    span
);

  key_t  key_r,  key_nxt;
  span_t span_r, span_nxt;

  always_comb begin
    key_nxt  = key_r;
    span_nxt = span_r;
    case (op)
      CELL_PUSH: begin
        key_nxt  = up_key;
        span_nxt = up_span;
      end
      CELL_POP: begin
        key_nxt  = dn_key;
        span_nxt = dn_span;
      end
      default: begin
        key_nxt  = key_r;
        span_nxt = span_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    span_r <= span_nxt;
  end

  assign key  = key_r;
  assign span = span_r;

endmodule

/* sv/ssms_ctrl.sv */
// ssms_ctrl: sequencer for the stack chain, fill count, history flag, result register.
// Depends on ssms_pkg.
module ssms_ctrl import ssms_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  key_t       top_key,
  input  span_t      top_span,
  output cell_ctrl_t cell_ctrl
);

  state_e    state_r, state_nxt;
  fill_t     fill_r, fill_nxt;
  logic      hist_r, hist_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  key_t      cur_key_r, cur_key_nxt;
  span_t     count_r, count_nxt;
  logic      sat_r, sat_nxt;

  logic                accept;
  logic                out_free;
  logic                pop_hit;
  logic [SPAN_WIDTH:0] sum;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign pop_hit  = (fill_r != FILL_EMPTY) && (top_key <= cur_key_r);
  assign sum      = {1'b0, count_r} + {1'b0, top_span};

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    hist_nxt      = hist_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    cur_key_nxt   = cur_key_r;
    count_nxt     = count_r;
    sat_nxt       = sat_r;
    cell_ctrl     = '{op: CELL_HOLD, key: cur_key_r, span: count_r};

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cur_key_nxt = price_to_key(in_item.price);
          count_nxt   = span_t'(1);
          sat_nxt     = 1'b0;
          if (in_item.series_start) begin
            fill_nxt = FILL_EMPTY;
            hist_nxt = 1'b0;
          end
          state_nxt = ST_WORK;
        end
      end
      ST_WORK: begin
        if (pop_hit) begin
          // pop one entry and fold its span in, saturating
          cell_ctrl.op = CELL_POP;
          fill_nxt     = fill_r - fill_t'(1);
          if (sum[SPAN_WIDTH]) begin
            count_nxt = SPAN_MAX;
            sat_nxt   = 1'b1;
          end else begin
            count_nxt = sum[SPAN_WIDTH-1:0];
          end
        end else if (out_free) begin
          // push; a full stack drops its bottom entry off the chain
          cell_ctrl.op = CELL_PUSH;
          if (fill_r == FILL_FULL) begin
            hist_nxt = 1'b1;
          end else begin
            fill_nxt = fill_r + fill_t'(1);
          end
          out_valid_nxt        = 1'b1;
          out_item_nxt.span    = count_r;
          out_item_nxt.inexact = sat_r || hist_r || (fill_r == FILL_FULL);
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= FILL_EMPTY;
      hist_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      hist_r      <= hist_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    cur_key_r  <= cur_key_nxt;
    count_r    <= count_nxt;
    sat_r      <= sat_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* sv/stock_span_monotonic_stack.sv */
// stock_span_monotonic_stack: top level; a controller over a chain of stack cells.
// Depends on ssms_pkg, ssms_cell and ssms_ctrl.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------
//   in_     | input     | in_valid / in_stall   | in_item_t  {price, series_start}
//   out_    | output    | out_valid / out_stall | out_item_t {span, inexact}
//
// An item is taken, then the entries it pops leave one at a time (the chain
// shifts up by one cell for each pop), and then the push loads the result
// register.
// The push waits while a previous result is still stalled on the output.
// Reset (rst_n low, synchronous) empties the stack and clears the history
// flag and the output valid; the cell contents are not reset.
// in_stall is high from the cycle after an item is taken until its push.
module stock_span_monotonic_stack import ssms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  cell_ctrl_t cell_ctrl;
  key_t       cell_key  [STACK_DEPTH];
  span_t      cell_span [STACK_DEPTH];

  // Sequencer: compares the top cell, counts the fill, owns the result register.
  ssms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .top_key   (cell_key[0]),
    .top_span  (cell_span[0]),
    .cell_ctrl (cell_ctrl)
  );

  // Cell 0 is the stack top. Push moves every cell one place down (the bottom
  // cell's entry falls off), pop moves every cell one place up.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    key_t  up_key, dn_key;
    span_t up_span, dn_span;

    if (i == 0) begin : g_top
      assign up_key  = cell_ctrl.key;
      assign up_span = cell_ctrl.span;
    end else begin : g_mid
      assign up_key  = cell_key[i-1];
      assign up_span = cell_span[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      // Nothing below the bottom: hold what is there, it lies beyond the fill.
      assign dn_key  = cell_key[i];
      assign dn_span = cell_span[i];
    end else begin : g_above
      assign dn_key  = cell_key[i+1];
      assign dn_span = cell_span[i+1];
    end

    ssms_cell u_cell (
      .clk     (clk),
      .op      (cell_ctrl.op),
      .up_key  (up_key),
      .up_span (up_span),
      .dn_key  (dn_key),
      .dn_span (dn_span),
      .key     (cell_key[i]),
      .span    (cell_span[i])
    );
  end

endmodule

/* sv/ssms_checker.sv */
// ssms_checker: port-level assertions for stock_span_monotonic_stack, bound to it.
// Depends on ssms_pkg and the top level's ports.
module ssms_checker import ssms_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // A span is never zero.
  a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.span != '0)
    else $error("zero span");

  // The input stalls right after every taken item, while that item is worked on.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken without work cycle");

  // A new result appears together with the return to ready.
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result loaded while still busy");

endmodule

bind stock_span_monotonic_stack ssms_checker u_ssms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
